FILE: src/timestamped_delay_fifo_macros.svh
// Assertion helpers used by the RTL.
`ifndef TIMESTAMPED_DELAY_FIFO_MACROS_SVH
`define TIMESTAMPED_DELAY_FIFO_MACROS_SVH

// Same-cycle implication, held off during reset.
`define TDF_ASSERT_NOW(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("tdf assertion failed");

// Next-cycle implication, held off during reset.
`define TDF_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("tdf assertion failed");

`endif

FILE: src/tdf_pkg.sv
package tdf_pkg;

  localparam int CMD_W    = 3;
  localparam int LENIN_W  = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int MLEN_W   = 12;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RECEIVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LARGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTDUE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE   = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [LENIN_W-1:0] length;
    logic [LENIN_W-1:0] capacity;
    logic [TIME_W-1:0]  now;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [MLEN_W-1:0]   message_length;
  } out_item_t;

endpackage

FILE: src/timestamped_delay_fifo.sv
// Channel  | Dir | Handshake             | Payload
// in       | in  | in_valid / in_ready   | in_item  (command, length, capacity, now)
// out      | out | out_valid / out_ready | out_item (status, slot, message_length)
// cfg      | in  | cfg_write             | cfg_index, cfg_data
//
// One request per cycle while in_ready; its response is registered into out or skid.
// Output register plus one skid entry: in_ready drops only while the skid entry is held.
// Head descriptor is prefetched from the descriptor memory, read at head_next.
// Reset (rst, synchronous) empties the ring and restores release_delay 0, gate_enable 1;
// descriptor memory is not cleared, occupancy comes from the fill count.
module timestamped_delay_fifo #(
  parameter int DEPTH      = 16,
  parameter int SLOT_BYTES = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tdf_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tdf_pkg::out_item_t                  out_item,
  input  logic                                cfg_write,
  input  logic [tdf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tdf_pkg::CFG_W-1:0]           cfg_data
);

`include "timestamped_delay_fifo_macros.svh"

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LEN_W = (SLOT_BYTES >= 65535) ? 16 : $clog2(SLOT_BYTES + 1);
  localparam int TW    = tdf_pkg::TIME_W;

  logic [15:0]      release_delay;
  logic             gate_enable;

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail_next;
  logic [CNT_W-1:0] count_next;

  logic [TW-1:0]    due_mem [DEPTH];
  logic [LEN_W-1:0] len_mem [DEPTH];
  logic [TW-1:0]    head_due;
  logic [LEN_W-1:0] head_len;

  tdf_pkg::out_item_t skid_item;
  logic               skid_valid;
  tdf_pkg::out_item_t res;

  logic             fire;
  logic             pop;
  logic             wr_en;
  logic             head_adv;
  logic             clr;
  logic             empty;
  logic             full;
  logic             len_big;
  logic [TW:0]      due_sum;
  logic [TW-1:0]    due_sat;
  logic [15:0]      head_len16;
  logic [15:0]      plen;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    return r;
  endfunction

  assign in_ready = !skid_valid;
  assign fire     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign len_big  = ({1'b0, in_item.length} > 17'(SLOT_BYTES));
  assign due_sum  = {1'b0, in_item.now} + (TW + 1)'(release_delay);
  assign due_sat  = due_sum[TW] ? '1 : due_sum[TW-1:0];
  assign head_len16 = 16'(head_len);

  always_comb begin
    res      = '0;
    wr_en    = 1'b0;
    head_adv = 1'b0;
    clr      = 1'b0;
    plen     = head_len16;
    case (in_item.command)
      tdf_pkg::CMD_PUSH: begin
        res.slot = 4'(tail);
        if (len_big) begin
          res.status = tdf_pkg::ST_LARGE;
        end else if (full) begin
          res.status = tdf_pkg::ST_FULL;
        end else if (in_item.length != '0) begin
          wr_en = fire;
          res.message_length = 12'(in_item.length);
        end
      end
      tdf_pkg::CMD_PEEK, tdf_pkg::CMD_RECEIVE: begin
        res.slot = 4'(head);
        if (empty) begin
          res.status = tdf_pkg::ST_EMPTY;
        end else if (gate_enable && (head_due > in_item.now)) begin
          res.status = tdf_pkg::ST_NOTDUE;
        end else begin
          if (in_item.command == tdf_pkg::CMD_RECEIVE) begin
            head_adv = fire;
            if (head_len16 > in_item.capacity) begin
              plen = in_item.capacity;
            end
          end
          res.message_length = 12'(plen);
        end
      end
      tdf_pkg::CMD_RELEASE: begin
        res.slot = 4'(head);
        if (empty) begin
          res.status = tdf_pkg::ST_EMPTY;
        end else begin
          head_adv = fire;
          res.message_length = 12'(head_len);
        end
      end
      tdf_pkg::CMD_CLEAR: begin
        clr = fire;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (clr) begin
      head_next  = '0;
      tail_next  = '0;
      count_next = '0;
    end else if (wr_en) begin
      tail_next  = idx_inc(tail);
      count_next = count + 1'b1;
    end else if (head_adv) begin
      head_next  = idx_inc(head);
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // descriptor memory: write at tail, prefetch the next head entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      due_mem[tail] <= due_sat;
      len_mem[tail] <= LEN_W'(in_item.length);
    end
    if (wr_en && (tail == head_next)) begin
      head_due <= due_sat;
      head_len <= LEN_W'(in_item.length);
    end else begin
      head_due <= due_mem[head_next];
      head_len <= len_mem[head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      release_delay <= '0;
      gate_enable   <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        tdf_pkg::REG_RELEASE_DELAY: release_delay <= cfg_data;
        tdf_pkg::REG_GATE_ENABLE:   gate_enable   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end
    end else if (fire) begin
      if (!out_valid || pop) begin
        out_item  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_item  <= res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  `TDF_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `TDF_ASSERT_NOW(a_ends_meet, clk, rst, (count == '0) || (count == CNT_W'(DEPTH)), head == tail)
  `TDF_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `TDF_ASSERT_NEXT(a_response_follows, clk, rst, in_valid && in_ready, out_valid)

endmodule

FILE: dv/tb_timestamped_delay_fifo.sv
module tb_timestamped_delay_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH    = 16;
  localparam int MAX_BYTES     = 2048;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int REPORT_LIMIT  = 10;
  localparam int HOLD_CYCLES   = 120;
  localparam logic [tdf_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = tdf_pkg::CMD_CLEAR + 3'd1;
  localparam logic [tdf_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  tdf_pkg::in_item_t             in_item;
  logic                          out_valid;
  logic                          out_ready;
  tdf_pkg::out_item_t            out_item;
  logic                          cfg_write;
  logic [tdf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tdf_pkg::CFG_W-1:0]     cfg_data;

  class ring_tracker;
    bit                  live[RING_DEPTH];
    bit [31:0]           due_at[RING_DEPTH];
    bit [11:0]           stored_len[RING_DEPTH];
    int                  head;
    int                  tail;
    bit [15:0]           delay;
    bit                  gate;
    tdf_pkg::out_item_t  pending_responses[$];
    int                  errors;

    function new();
      delay = '0;
      gate = 1'b1;
      errors = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      for (int i = 0; i < RING_DEPTH; i++) begin
        live[i] = 1'b0;
      end
      head = 0;
      tail = 0;
    endfunction

    function int step_index(int i);
      return (i == RING_DEPTH - 1) ? 0 : i + 1;
    endfunction

    function void set_reg(logic [tdf_pkg::CFG_IDX_W-1:0] idx,
                          logic [tdf_pkg::CFG_W-1:0] val);
      if (idx == tdf_pkg::REG_RELEASE_DELAY) begin
        delay = val;
      end else if (idx == tdf_pkg::REG_GATE_ENABLE) begin
        gate = val[0];
      end
    endfunction

    function tdf_pkg::out_item_t ring_response(tdf_pkg::in_item_t rq);
      tdf_pkg::out_item_t r;
      bit [32:0] sum;
      bit [15:0] plen;
      r = '0;
      r.status = tdf_pkg::ST_OK;
      case (rq.command)
        tdf_pkg::CMD_PUSH: begin
          r.slot = tdf_pkg::SLOT_W'(tail);
          if (rq.length > MAX_BYTES) begin
            r.status = tdf_pkg::ST_LARGE;
          end else if (live[tail]) begin
            r.status = tdf_pkg::ST_FULL;
          end else if (rq.length != 0) begin
            sum = {1'b0, rq.now} + {17'd0, delay};
            due_at[tail] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            stored_len[tail] = rq.length[11:0];
            live[tail] = 1'b1;
            r.message_length = rq.length[11:0];
            tail = step_index(tail);
          end
        end
        tdf_pkg::CMD_PEEK, tdf_pkg::CMD_RECEIVE: begin
          r.slot = tdf_pkg::SLOT_W'(head);
          if (!live[head]) begin
            r.status = tdf_pkg::ST_EMPTY;
          end else if (gate && due_at[head] > rq.now) begin
            r.status = tdf_pkg::ST_NOTDUE;
          end else begin
            plen = {4'd0, stored_len[head]};
            if (rq.command == tdf_pkg::CMD_RECEIVE) begin
              if (plen > rq.capacity) plen = rq.capacity;
              live[head] = 1'b0;
              head = step_index(head);
            end
            r.message_length = plen[11:0];
          end
        end
        tdf_pkg::CMD_RELEASE: begin
          r.slot = tdf_pkg::SLOT_W'(head);
          if (!live[head]) begin
            r.status = tdf_pkg::ST_EMPTY;
          end else begin
            r.message_length = stored_len[head];
            live[head] = 1'b0;
            head = step_index(head);
          end
        end
        tdf_pkg::CMD_CLEAR: begin
          clear_ring();
        end
        default: begin
        end
      endcase
      return r;
    endfunction

    function void log_request(tdf_pkg::in_item_t rq);
      pending_responses.push_back(ring_response(rq));
    endfunction

    function void match_response(tdf_pkg::out_item_t got);
      tdf_pkg::out_item_t want;
      if (pending_responses.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("unexpected response: status %0d slot %0d length %0d",
                   got.status, got.slot, got.message_length);
        end
      end else begin
        want = pending_responses.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("mismatch (status/slot/length): expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     want.status, want.slot, want.message_length,
                     got.status, got.slot, got.message_length);
          end
        end
      end
    endfunction
  endclass

  ring_tracker tracker = new();

  bit [31:0] clock_now;
  bit        sink_hold_req;
  int        burst_left;

  timestamped_delay_fifo #(
    .DEPTH      (RING_DEPTH),
    .SLOT_BYTES (MAX_BYTES)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.log_request(in_item);
      if (out_valid && out_ready) tracker.match_response(out_item);
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_timestamped_delay_fifo: done, errors");
    $finish;
  end

  initial begin
    int  r;
    int  n;
    bit  val;
    out_ready = 1'b0;
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        val = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          val = 1'b1;
          n = $urandom_range(20, 60);
        end else if (r < 70) begin
          val = 1'b1;
          n = 1;
        end else if (r < 95) begin
          val = 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          val = 1'b0;
          n = $urandom_range(15, 40);
        end
      end
      out_ready <= val;
      repeat (n) @(posedge clk);
    end
  end

  function int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  function tdf_pkg::in_item_t req(logic [tdf_pkg::CMD_W-1:0] cmd,
                                  logic [tdf_pkg::LENIN_W-1:0] len,
                                  logic [tdf_pkg::LENIN_W-1:0] cap,
                                  logic [tdf_pkg::TIME_W-1:0] now);
    tdf_pkg::in_item_t rq;
    rq.command = cmd;
    rq.length = len;
    rq.capacity = cap;
    rq.now = now;
    return rq;
  endfunction

  function tdf_pkg::in_item_t random_request(int push_pct, int jump_pct);
    tdf_pkg::in_item_t rq;
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    if (r < push_pct) rq.command = tdf_pkg::CMD_PUSH;
    else if (s < 45) rq.command = tdf_pkg::CMD_RECEIVE;
    else if (s < 70) rq.command = tdf_pkg::CMD_PEEK;
    else if (s < 92) rq.command = tdf_pkg::CMD_RELEASE;
    else if (s < 97) rq.command = tdf_pkg::CMD_CLEAR;
    else rq.command = tdf_pkg::CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));

    r = $urandom_range(0, 99);
    if (r < 5) rq.length = '0;
    else if (r < 9) rq.length = tdf_pkg::LENIN_W'($urandom_range(MAX_BYTES + 1, 65535));
    else if (r < 12) rq.length = '1;
    else if (r < 16) rq.length = tdf_pkg::LENIN_W'(MAX_BYTES);
    else rq.length = tdf_pkg::LENIN_W'($urandom_range(1, MAX_BYTES));

    r = $urandom_range(0, 99);
    if (r < 40) rq.capacity = tdf_pkg::LENIN_W'($urandom_range(0, 65535));
    else if (r < 85) rq.capacity = tdf_pkg::LENIN_W'($urandom_range(0, MAX_BYTES));
    else if (r < 92) rq.capacity = '0;
    else rq.capacity = '1;

    r = $urandom_range(0, 99);
    if (r < jump_pct) clock_now += $urandom_range(1000, 70000);
    else clock_now += $urandom_range(0, 3);
    rq.now = ($urandom_range(0, 99) < 3) ? tdf_pkg::TIME_W'($urandom) : clock_now;
    return rq;
  endfunction

  task automatic issue(tdf_pkg::in_item_t rq, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= rq;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [tdf_pkg::CFG_IDX_W-1:0] idx,
                           logic [tdf_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic run_directed();
    issue(req(tdf_pkg::CMD_PEEK, '0, '0, '0), pick_gap());
    issue(req(tdf_pkg::CMD_RELEASE, '0, '0, '0), pick_gap());
    issue(req(tdf_pkg::CMD_PUSH, '0, 16'd7, 32'd5), pick_gap());
    issue(req(tdf_pkg::CMD_PUSH, '1, '1, '1), pick_gap());
    issue(req(tdf_pkg::CMD_PUSH, tdf_pkg::LENIN_W'(MAX_BYTES), '0, '0), pick_gap());
    issue(req(tdf_pkg::CMD_PUSH, 16'd1, '0, '1), pick_gap());
    for (int i = 2; i < RING_DEPTH; i++) begin
      issue(req(tdf_pkg::CMD_PUSH, tdf_pkg::LENIN_W'(i * 100), '0, 32'd10), pick_gap());
    end
    issue(req(tdf_pkg::CMD_PUSH, 16'd10, '0, 32'd10), pick_gap());
    issue(req(tdf_pkg::CMD_PEEK, '0, '0, '0), pick_gap());
    issue(req(tdf_pkg::CMD_RECEIVE, '0, 16'd100, '0), pick_gap());
    issue(req(tdf_pkg::CMD_PEEK, '0, '0, 32'hFFFF_FFFE), pick_gap());
    issue(req(tdf_pkg::CMD_RELEASE, '0, '0, '0), pick_gap());
    issue(req(CMD_UNUSED_LAST, '1, '1, '1), pick_gap());
    issue(req(tdf_pkg::CMD_CLEAR, '0, '0, '0), pick_gap());
    settle();

    write_reg(tdf_pkg::REG_RELEASE_DELAY, '1);
    issue(req(tdf_pkg::CMD_PUSH, tdf_pkg::LENIN_W'(MAX_BYTES), '0, '1), pick_gap());
    issue(req(tdf_pkg::CMD_PEEK, '0, '0, 32'hFFFF_FFFE), pick_gap());
    issue(req(tdf_pkg::CMD_RECEIVE, '0, '1, '1), pick_gap());
    issue(req(tdf_pkg::CMD_PUSH, 16'd1, '0, 32'hFFFF_0000), pick_gap());
    settle();
  endtask

  task automatic run_random(int count, int push_pct, int jump_pct, int hold_at,
                            int drain_at);
    for (int i = 0; i < count; i++) begin
      if (i == drain_at) settle();
      if (i == hold_at) begin
        sink_hold_req = 1'b1;
        burst_left = 40;
      end
      issue(random_request(push_pct, jump_pct), pick_gap());
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_write = 1'b0;
    cfg_index = tdf_pkg::REG_RELEASE_DELAY;
    cfg_data = '0;
    clock_now = '0;
    sink_hold_req = 1'b0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    write_reg(tdf_pkg::REG_RELEASE_DELAY, '0);
    write_reg(tdf_pkg::REG_GATE_ENABLE, tdf_pkg::CFG_W'(1));
    run_random(150, 45, 0, -1, 75);

    write_reg(tdf_pkg::REG_RELEASE_DELAY, tdf_pkg::CFG_W'($urandom_range(1, 20)));
    run_random(200, 50, 0, 60, -1);

    clock_now = 32'hFFFF_F000;
    write_reg(tdf_pkg::REG_RELEASE_DELAY, '1);
    write_reg(tdf_pkg::REG_GATE_ENABLE, '0);
    run_random(150, 50, 5, -1, -1);

    write_reg(tdf_pkg::REG_GATE_ENABLE, tdf_pkg::CFG_W'(1));
    run_random(100, 45, 30, -1, -1);

    write_reg(tdf_pkg::REG_RELEASE_DELAY, tdf_pkg::CFG_W'($urandom_range(0, 65535)));
    write_reg(tdf_pkg::REG_GATE_ENABLE, tdf_pkg::CFG_W'($urandom_range(0, 1)));
    run_random(250, 60, 10, 120, -1);

    in_valid <= 1'b0;
    while (tracker.pending_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_responses.size() == 0) begin
      $display("tb_timestamped_delay_fifo: done, clean");
    end else begin
      $display("tb_timestamped_delay_fifo: done, errors");
    end
    $finish;
  end

endmodule
